/* design/plt_pkg.sv */
// Shared types and constants for the polygon-list fan triangulator.
// Used by every design file; depends on nothing.
`timescale 1ns / 1ps

package plt_pkg;

   // Parser phase: where the next byte lands in the polygon record.
   typedef enum logic [2:0] {
      PH_CNT_HI = 3'd0,
      PH_CNT_LO = 3'd1,
      PH_IDX_HI = 3'd2,
      PH_IDX_LO = 3'd3,
      PH_EXT_HI = 3'd4,
      PH_EXT_LO = 3'd5
   } phase_type;

   // Kind of a result item.
   typedef enum logic {
      KIND_TRIANGLE = 1'b0,
      KIND_END      = 1'b1
   } kind_type;

   localparam int INDEX_BITS  = 24;
   localparam int CORNER_BITS = 25;
   localparam int TOTAL_BITS  = 24;

   // A high index byte of all ones starts a 24-bit index.
   localparam logic [7:0]            EXT_MARK  = 8'hFF;
   localparam logic [15:0]           MIN_NODES = 16'd3;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 24'hFFFFFF;

   // Register file decode: one register, word address bit selects it.
   localparam int         CSR_ADDR_BITS  = 3;
   localparam logic [0:0] REG_INDEX_BIAS = 1'b0;

   typedef struct packed {
      kind_type                item_kind;
      logic [CORNER_BITS-1:0]  corner_first;
      logic [CORNER_BITS-1:0]  corner_second;
      logic [CORNER_BITS-1:0]  corner_third;
      logic [TOTAL_BITS-1:0]   triangle_total;
      logic                    run_last;
   } rsp_item_type;

   // Results produced by one input byte: zero, one or two items.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

/* design/plt_if.sv */
// Channel interfaces for the byte input and the result output.
// Depends on plt_pkg for field widths.
`timescale 1ns / 1ps

interface plt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_last;

   modport source (output valid, data_byte, chunk_last, input ready);
   modport sink   (input valid, data_byte, chunk_last, output ready);
endinterface

interface plt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                item_kind;
   logic [plt_pkg::CORNER_BITS-1:0]     corner_first;
   logic [plt_pkg::CORNER_BITS-1:0]     corner_second;
   logic [plt_pkg::CORNER_BITS-1:0]     corner_third;
   logic [plt_pkg::TOTAL_BITS-1:0]      triangle_total;
   logic                                run_last;

   modport source (output valid, item_kind, corner_first, corner_second, corner_third,
                   triangle_total, run_last, input ready);
   modport sink   (input valid, item_kind, corner_first, corner_second, corner_third,
                   triangle_total, run_last, output ready);
endinterface

/* design/plt_csr.sv */
// APB-style register file holding the index bias.
// Depends on plt_pkg for the address decode constants.
`timescale 1ns / 1ps

module plt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [plt_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output logic [plt_pkg::INDEX_BITS-1:0]       index_bias
);

   logic [plt_pkg::INDEX_BITS-1:0] bias_ff;
   logic                           sel_bias;
   logic                           wr_en;

   // Address decode on the word index.
   always_comb begin
      unique case (paddr[2])
         plt_pkg::REG_INDEX_BIAS: sel_bias = 1'b1;
         default:                 sel_bias = 1'b0;
      endcase
   end

   assign wr_en  = psel && penable && pwrite && sel_bias;
   assign pready = 1'b1;
   assign prdata = sel_bias ? {8'h00, bias_ff} : 32'h0;
   assign index_bias = bias_ff;

   // Bias register; writes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (wr_en) begin
         bias_ff <= pwdata[plt_pkg::INDEX_BITS-1:0];
      end
   end

endmodule

/* design/plt_parse.sv */
// Byte parser and fan builder: input register, polygon state and result forming.
// Depends on plt_pkg for phase codes and the result item types.
`timescale 1ns / 1ps

module plt_parse #(
   parameter int COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [7:0]                        in_byte,
   input  logic                              in_last,
   input  logic [plt_pkg::INDEX_BITS-1:0]    index_bias,
   input  logic                              room,
   output logic                              push_vld,
   output plt_pkg::push_type                 push
);

   localparam int WideBits = (COUNT_BITS > plt_pkg::TOTAL_BITS) ? COUNT_BITS
                                                                  : plt_pkg::TOTAL_BITS;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       adv;

   // Parser state.
   plt_pkg::phase_type                 phase_ff, phase_in;
   logic [plt_pkg::INDEX_BITS-1:0]     wbuf_ff, wbuf_in;
   logic [15:0]                        nodes_ff, nodes_in;
   logic [1:0]                         seen_ff, seen_in;
   logic                               skip_ff, skip_in;
   logic [plt_pkg::INDEX_BITS-1:0]     pivot_ff, pivot_in;
   logic [plt_pkg::INDEX_BITS-1:0]     prev_ff, prev_in;
   logic [COUNT_BITS-1:0]              count_ff, count_in;

   // Working values.
   logic [15:0]                        cnt_word;
   logic [15:0]                        nodes_dec;
   logic                               ext_start;
   plt_pkg::phase_type                 corner_phase;
   logic                               corner_vld;
   logic [plt_pkg::INDEX_BITS-1:0]     corner_val;
   logic                               made;
   logic [WideBits-1:0]                count_wide;
   logic [plt_pkg::TOTAL_BITS-1:0]     total_sat;
   plt_pkg::rsp_item_type              tri_item;
   plt_pkg::rsp_item_type              end_item;

   assign adv      = in_vld_ff && room;
   assign in_ready = !in_vld_ff || room;

   assign cnt_word     = {wbuf_ff[7:0], in_byte_ff};
   assign nodes_dec    = nodes_ff - 16'd1;
   assign ext_start    = (wbuf_ff[7:0] == plt_pkg::EXT_MARK);
   assign corner_phase = (nodes_dec == 16'd0) ? plt_pkg::PH_CNT_HI : plt_pkg::PH_IDX_HI;

   // Next phase. A chunk end always returns to the node count.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         plt_pkg::PH_CNT_LO:
            phase_in = (cnt_word == 16'd0) ? plt_pkg::PH_CNT_HI : plt_pkg::PH_IDX_HI;
         plt_pkg::PH_IDX_HI: phase_in = plt_pkg::PH_IDX_LO;
         plt_pkg::PH_IDX_LO: phase_in = ext_start ? plt_pkg::PH_EXT_HI : corner_phase;
         plt_pkg::PH_EXT_HI: phase_in = plt_pkg::PH_EXT_LO;
         plt_pkg::PH_EXT_LO: phase_in = corner_phase;
         default:            phase_in = plt_pkg::PH_CNT_LO;
      endcase
      if (in_last_ff) begin
         phase_in = plt_pkg::PH_CNT_HI;
      end
   end

   // Byte decode and corner assembly.
   always_comb begin
      wbuf_in    = wbuf_ff;
      nodes_in   = nodes_ff;
      seen_in    = seen_ff;
      skip_in    = skip_ff;
      corner_vld = 1'b0;
      corner_val = '0;
      case (phase_ff)
         plt_pkg::PH_CNT_LO: begin
            nodes_in = cnt_word;
            seen_in  = 2'd0;
            skip_in  = (cnt_word < plt_pkg::MIN_NODES);
         end
         plt_pkg::PH_IDX_HI: wbuf_in = {16'h0000, in_byte_ff};
         plt_pkg::PH_IDX_LO: begin
            if (ext_start) begin
               wbuf_in = {in_byte_ff, 16'h0000};
            end else begin
               corner_vld = 1'b1;
               corner_val = {8'h00, wbuf_ff[7:0], in_byte_ff};
            end
         end
         plt_pkg::PH_EXT_HI: wbuf_in = {wbuf_ff[23:16], in_byte_ff, 8'h00};
         plt_pkg::PH_EXT_LO: begin
            corner_vld = 1'b1;
            corner_val = {wbuf_ff[23:8], in_byte_ff};
         end
         default: wbuf_in = {16'h0000, in_byte_ff};
      endcase
      if (corner_vld) begin
         nodes_in = nodes_dec;
      end
      if (in_last_ff) begin
         wbuf_in  = '0;
         nodes_in = '0;
         seen_in  = '0;
         skip_in  = 1'b0;
      end
      if (corner_vld && !skip_ff && (seen_ff == 2'd0)) begin
         seen_in = in_last_ff ? 2'd0 : 2'd1;
      end else if (corner_vld && !skip_ff && (seen_ff == 2'd1)) begin
         seen_in = in_last_ff ? 2'd0 : 2'd2;
      end
   end

   // Fan: pivot, then previous, then one triangle per further corner.
   always_comb begin
      pivot_in = pivot_ff;
      prev_in  = prev_ff;
      count_in = count_ff;
      made     = 1'b0;
      if (corner_vld && !skip_ff) begin
         case (seen_ff)
            2'd0:    pivot_in = corner_val;
            2'd1:    prev_in  = corner_val;
            default: begin
               made    = 1'b1;
               prev_in = corner_val;
               if (count_ff != CountMax) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
         endcase
      end
   end

   // Total saturates to the output width.
   assign count_wide = WideBits'(count_in);
   assign total_sat  = (count_wide > WideBits'(plt_pkg::TOTAL_MAX))
                       ? plt_pkg::TOTAL_MAX : count_wide[plt_pkg::TOTAL_BITS-1:0];

   // Result items for this byte.
   always_comb begin
      tri_item.item_kind      = plt_pkg::KIND_TRIANGLE;
      tri_item.corner_first   = {1'b0, pivot_ff} + {1'b0, index_bias};
      tri_item.corner_second  = {1'b0, prev_ff} + {1'b0, index_bias};
      tri_item.corner_third   = {1'b0, corner_val} + {1'b0, index_bias};
      tri_item.triangle_total = '0;
      tri_item.run_last       = !in_last_ff;

      end_item.item_kind      = plt_pkg::KIND_END;
      end_item.corner_first   = '0;
      end_item.corner_second  = '0;
      end_item.corner_third   = '0;
      end_item.triangle_total = total_sat;
      end_item.run_last       = 1'b1;

      push.count  = 2'(made) + 2'(in_last_ff);
      push.first  = made ? tri_item : end_item;
      push.second = end_item;
   end

   assign push_vld = adv;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_ready) begin
         in_vld_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         in_byte_ff <= in_byte;
         in_last_ff <= in_last;
      end
   end

   // Parser state registers; a chunk end clears everything.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= plt_pkg::PH_CNT_HI;
         wbuf_ff  <= '0;
         nodes_ff <= '0;
         seen_ff  <= '0;
         skip_ff  <= 1'b0;
         pivot_ff <= '0;
         prev_ff  <= '0;
         count_ff <= '0;
      end else if (adv) begin
         phase_ff <= phase_in;
         wbuf_ff  <= wbuf_in;
         nodes_ff <= nodes_in;
         seen_ff  <= seen_in;
         skip_ff  <= skip_in;
         pivot_ff <= in_last_ff ? '0 : pivot_in;
         prev_ff  <= in_last_ff ? '0 : prev_in;
         count_ff <= in_last_ff ? '0 : count_in;
      end
   end

endmodule

/* design/plt_queue.sv */
// Four-entry result queue taking up to two items per cycle and giving one.
// Depends on plt_pkg for the result item types.
`timescale 1ns / 1ps

module plt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_vld,
   input  plt_pkg::push_type       push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output plt_pkg::rsp_item_type   out_item
);

   localparam int QDepth  = 4;
   localparam int PtrBits = $clog2(QDepth);
   localparam int LvlBits = PtrBits + 1;

   plt_pkg::rsp_item_type     mem_ff [QDepth];
   logic [PtrBits-1:0]        wp_ff, wp_in;
   logic [PtrBits-1:0]        rp_ff, rp_in;
   logic [LvlBits-1:0]        level_ff, level_in;
   logic [1:0]                pushes;
   logic                      pop;

   // Room for the worst case of two items from one byte.
   assign room      = (level_ff <= LvlBits'(QDepth - 2));
   assign out_valid = (level_ff != '0);
   assign out_item  = mem_ff[rp_ff];

   assign pushes   = push_vld ? push.count : 2'd0;
   assign pop      = out_valid && out_ready;
   assign wp_in    = wp_ff + PtrBits'(pushes);
   assign rp_in    = rp_ff + PtrBits'(pop);
   assign level_in = level_ff + LvlBits'(pushes) - LvlBits'(pop);

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         level_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         level_ff <= level_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (pushes != 2'd0) begin
         mem_ff[wp_ff] <= push.first;
      end
      if (pushes == 2'd2) begin
         mem_ff[wp_ff + PtrBits'(1)] <= push.second;
      end
   end

endmodule

/* design/polygon_list_fan_triangulator.sv */
// Top level of the polygon-list fan triangulator: register file, parser and result queue.
// Depends on plt_pkg, plt_if, plt_csr, plt_parse and plt_queue.
//
//   Channel  Direction  Payload
//   req_ch   in         data_byte[7:0], chunk_last
//   rsp_ch   out        item_kind, corner_first/second/third[24:0], triangle_total[23:0],
//                       run_last
//   csr_*    in         APB write/read of index_bias at byte address 0
//
// One byte is taken every cycle while the queue has room; its first result passes the
// input register and the queue. A byte that yields two items (triangle and end item)
// fills two queue slots; the four-entry queue takes a byte whenever at least two slots
// are free. Reset is synchronous and returns the parser to the node count with an empty
// queue. A stalled output fills the queue and then holds req_ch.ready low.
`timescale 1ns / 1ps

module polygon_list_fan_triangulator #(
   parameter int COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   plt_req_if.sink                           req_ch,
   plt_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [plt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [plt_pkg::INDEX_BITS-1:0] index_bias;
   logic                           room;
   logic                           push_vld;
   plt_pkg::push_type              push;
   plt_pkg::rsp_item_type          out_item;

   plt_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .index_bias (index_bias)
   );

   plt_parse #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_byte    (req_ch.data_byte),
      .in_last    (req_ch.chunk_last),
      .index_bias (index_bias),
      .room       (room),
      .push_vld   (push_vld),
      .push       (push)
   );

   plt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push      (push),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   // Result fields.
   assign rsp_ch.item_kind      = out_item.item_kind;
   assign rsp_ch.corner_first   = out_item.corner_first;
   assign rsp_ch.corner_second  = out_item.corner_second;
   assign rsp_ch.corner_third   = out_item.corner_third;
   assign rsp_ch.triangle_total = out_item.triangle_total;
   assign rsp_ch.run_last       = out_item.run_last;

   // An end item always closes the run of its byte.
   a_end_is_run_last : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.item_kind == plt_pkg::KIND_END) |-> rsp_ch.run_last)
      else $error("end item without run_last");

   // An end item carries no corners; a triangle carries no total.
   a_end_no_corners : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.item_kind == plt_pkg::KIND_END) |->
      (rsp_ch.corner_first == '0) && (rsp_ch.corner_second == '0) &&
      (rsp_ch.corner_third == '0))
      else $error("end item with corner data");

   a_tri_no_total : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.item_kind == plt_pkg::KIND_TRIANGLE) |->
      (rsp_ch.triangle_total == '0))
      else $error("triangle item with a total");

   // The queue is empty right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

endmodule

/* dv/tb.sv */
// Testbench for the polygon-list fan triangulator: polygon chunk bytes in, triangles out.
// Depends on plt_pkg, plt_if and polygon_list_fan_triangulator. A scoreboard class
// predicts every result item from the accepted bytes and checks the block's output.
`timescale 1ns / 1ps

module tb;
   import plt_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int ITEMS_PER_PHASE = 275;

   localparam logic [CSR_ADDR_BITS-1:0] BIAS_ADDR  = {REG_INDEX_BIAS, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = {~REG_INDEX_BIAS, 2'b00};

   // Tracks the parser state of the block and holds the result items still owed.
   class fan_scoreboard;
      logic [INDEX_BITS-1:0] index_bias;
      phase_type             phase;
      logic [23:0]           word_buf;
      logic [15:0]           nodes_left;
      logic [1:0]            corners;
      bit                    skipping;
      logic [INDEX_BITS-1:0] pivot;
      logic [INDEX_BITS-1:0] prev;
      logic [TOTAL_BITS-1:0] triangle_count;
      rsp_item_type          due_items[$];
      int                    errors;

      function new();
         index_bias = '0;
         errors     = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         phase          = PH_CNT_HI;
         word_buf       = '0;
         nodes_left     = '0;
         corners        = '0;
         skipping       = 1'b0;
         pivot          = '0;
         prev           = '0;
         triangle_count = '0;
      endfunction

      // Only the bias register exists; writes to other words are dropped.
      function void write_register(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] data);
         if (addr[CSR_ADDR_BITS-1:2] == REG_INDEX_BIAS) begin
            index_bias = data[INDEX_BITS-1:0];
         end
      endfunction

      function logic [CORNER_BITS-1:0] biased(logic [INDEX_BITS-1:0] idx);
         return {1'b0, idx} + {1'b0, index_bias};
      endfunction

      function rsp_item_type make_item(kind_type kind, logic [CORNER_BITS-1:0] a,
                                       logic [CORNER_BITS-1:0] b,
                                       logic [CORNER_BITS-1:0] c,
                                       logic [TOTAL_BITS-1:0] total);
         rsp_item_type item;
         item.item_kind      = kind;
         item.corner_first   = a;
         item.corner_second  = b;
         item.corner_third   = c;
         item.triangle_total = total;
         item.run_last       = 1'b0;
         return item;
      endfunction

      // A finished corner either fills the pivot or previous slot, or closes a triangle.
      function int take_corner(logic [INDEX_BITS-1:0] corner);
         int made;
         made = 0;
         if (!skipping) begin
            if (corners == 2'd0) begin
               pivot   = corner;
               corners = 2'd1;
            end else if (corners == 2'd1) begin
               prev    = corner;
               corners = 2'd2;
            end else begin
               due_items.push_back(make_item(KIND_TRIANGLE, biased(pivot), biased(prev),
                                             biased(corner), '0));
               prev = corner;
               if (triangle_count != TOTAL_MAX) begin
                  triangle_count++;
               end
               made = 1;
            end
         end
         nodes_left--;
         phase = (nodes_left == 16'd0) ? PH_CNT_HI : PH_IDX_HI;
         return made;
      endfunction

      // Advances the parser by one accepted byte and queues the items it causes.
      function void parse_byte(logic [7:0] b, logic last);
         int           n;
         rsp_item_type tail;
         n = 0;
         case (phase)
            PH_CNT_LO: begin
               nodes_left = {word_buf[7:0], b};
               corners    = '0;
               skipping   = (nodes_left < MIN_NODES);
               phase      = (nodes_left == 16'd0) ? PH_CNT_HI : PH_IDX_HI;
            end
            PH_IDX_HI: begin
               word_buf = {16'd0, b};
               phase    = PH_IDX_LO;
            end
            PH_IDX_LO: begin
               if (word_buf[7:0] == EXT_MARK) begin
                  word_buf = {b, 16'd0};
                  phase    = PH_EXT_HI;
               end else begin
                  n += take_corner({8'd0, word_buf[7:0], b});
               end
            end
            PH_EXT_HI: begin
               word_buf = {word_buf[23:16], b, 8'd0};
               phase    = PH_EXT_LO;
            end
            PH_EXT_LO: begin
               n += take_corner({word_buf[23:8], b});
            end
            default: begin
               word_buf = {16'd0, b};
               phase    = PH_CNT_LO;
            end
         endcase
         if (last) begin
            due_items.push_back(make_item(KIND_END, '0, '0, '0, triangle_count));
            n++;
            clear_parser();
         end
         // The final item of this byte carries the run marker.
         if (n > 0) begin
            tail          = due_items.pop_back();
            tail.run_last = 1'b1;
            due_items.push_back(tail);
         end
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_item(rsp_item_type got);
         rsp_item_type want;
         if (due_items.size() == 0) begin
            $display("%0t: unexpected item: expected none, got kind %0d total %0d",
                     $time, got.item_kind, got.triangle_total);
            errors++;
         end else begin
            want = due_items.pop_front();
            check_field("item_kind", want.item_kind, got.item_kind);
            check_field("corner_first", want.corner_first, got.corner_first);
            check_field("corner_second", want.corner_second, got.corner_second);
            check_field("corner_third", want.corner_third, got.corner_third);
            check_field("triangle_total", want.triangle_total, got.triangle_total);
            check_field("run_last", want.run_last, got.run_last);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   plt_req_if req_ch();
   plt_rsp_if rsp_ch();

   fan_scoreboard board;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            calm;
   int            stall_free;
   int            idle_cycles;
   int            bytes_sent;
   logic [7:0]    chunk_bytes[$];

   polygon_list_fan_triangulator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result receiver: random stalls, broken up by runs of steady acceptance.
   always @(negedge clock) begin
      if (stall_free > 0) begin
         stall_free--;
         rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
         stall_free = $urandom_range(10, 30);
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor and watchdog: checks results, feeds accepted bytes to the predictor.
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.item_kind      = kind_type'(rsp_ch.item_kind);
            got.corner_first   = rsp_ch.corner_first;
            got.corner_second  = rsp_ch.corner_second;
            got.corner_third   = rsp_ch.corner_third;
            got.triangle_total = rsp_ch.triangle_total;
            got.run_last       = rsp_ch.run_last;
            board.check_item(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            board.parse_byte(req_ch.data_byte, req_ch.chunk_last);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || csr_psel) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: watchdog: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // One APB write; psel stays high so writes can follow back to back.
   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_register(addr, data);
      @(negedge clock);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Sends one byte, with random idle cycles ahead of it unless the chunk runs calm.
   task automatic send_byte(logic [7:0] b, logic last);
      while (!calm && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.chunk_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_chunk();
      calm = ($urandom_range(0, 3) == 0);
      foreach (chunk_bytes[i]) begin
         send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
      end
      chunk_bytes.delete();
   endtask

   function automatic void add_word(logic [15:0] w);
      chunk_bytes.push_back(w[15:8]);
      chunk_bytes.push_back(w[7:0]);
   endfunction

   // Indices from 0xFF00 up need the long form; smaller ones may use it too.
   function automatic void add_index(logic [23:0] idx, bit long_form);
      if (long_form || idx >= 24'h00FF00) begin
         add_word({EXT_MARK, idx[23:16]});
         add_word(idx[15:0]);
      end else begin
         add_word(idx[15:0]);
      end
   endfunction

   function automatic logic [23:0] random_index();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 3))
            0:       return 24'h000000;
            1:       return 24'h00FEFF;
            2:       return 24'h00FF00;
            default: return 24'hFFFFFF;
         endcase
      end else if (pick < 6) begin
         return 24'($urandom_range(0, 'hFEFF));
      end
      return 24'($urandom_range(0, 'hFFFFFF));
   endfunction

   // Mostly well-formed chunks; some are noise, cut short or end inside a huge polygon.
   task automatic random_chunk();
      int polys;
      int pick;
      int nodes;
      int cut;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 16)) chunk_bytes.push_back(8'($urandom));
      end else begin
         polys = $urandom_range(1, 6);
         for (int p = 0; p < polys; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               nodes = 0;
            end else if (pick < 20) begin
               nodes = $urandom_range(1, 2);
            end else begin
               nodes = $urandom_range(3, 8);
            end
            add_word(16'(nodes));
            repeat (nodes) add_index(random_index(), $urandom_range(0, 4) == 0);
         end
         if ($urandom_range(0, 9) == 0) begin
            add_word(16'($urandom_range('h0100, 'hFFFF)));
            repeat ($urandom_range(0, 5)) add_index(random_index(), $urandom_range(0, 4) == 0);
         end
         if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, chunk_bytes.size() - 1);
            while (chunk_bytes.size() > cut) void'(chunk_bytes.pop_back());
         end
      end
      send_chunk();
   endtask

   task automatic directed_chunks();
      // Empty polygon, a one-node polygon, then a quad mixing short and long indices;
      // its second triangle is closed by the chunk's final byte.
      add_word(16'd0);
      add_word(16'd1);
      add_index(24'd7, 1'b0);
      add_word(16'd4);
      add_index(24'h000000, 1'b0);
      add_index(24'h00FEFF, 1'b0);
      add_index(24'hFFFFFF, 1'b1);
      add_index(24'h001234, 1'b1);
      send_chunk();
      // Full 16-bit node count: one triangle, then the chunk stops inside an index.
      add_word(16'hFFFF);
      add_index(24'd1, 1'b0);
      add_index(24'd2, 1'b0);
      add_index(24'd3, 1'b0);
      chunk_bytes.push_back(8'h80);
      send_chunk();
   endtask

   // Waits until every owed item has come back and the pipeline has settled.
   task automatic wait_idle();
      while (board.due_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int target;
      board             = new();
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      req_ch.chunk_last = 1'b0;
      rsp_ch.ready      = 1'b0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      calm              = 1'b0;
      stall_free        = 0;
      idle_cycles       = 0;
      bytes_sent        = 0;
      target            = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Four phases of handshake pressure, each with its own bias setting.
      for (int p = 0; p < 4; p++) begin
         // The last byte of the previous phase must not be offered again.
         req_ch.valid <= 1'b0;
         wait_idle();
         case (p)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               csr_write(BIAS_ADDR, 32'h00FF_FFFF);
            end
            1: begin
               send_idle_pct  = 60;
               recv_stall_pct = 0;
               csr_write(BIAS_ADDR, 32'd0);
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 60;
               csr_write(BIAS_ADDR, $urandom);
            end
            default: begin
               send_idle_pct  = 35;
               recv_stall_pct = 35;
               csr_write(SPARE_ADDR, $urandom);
               csr_write(BIAS_ADDR, $urandom);
            end
         endcase
         csr_release();
         if (p == 0) begin
            directed_chunks();
         end
         target += ITEMS_PER_PHASE;
         while (bytes_sent < target) random_chunk();
      end
      req_ch.valid <= 1'b0;
      wait_idle();

      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
